### src/adcc_pkg.sv
// shared types and constants for the adc channel conditioner
// no dependencies; used by adc_channel_conditioner, adcc_ctrl and adcc_dpath
`default_nettype none

package adcc_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_COUNT_SCALE     = 2'd0;
   localparam logic [1:0] CSR_VOLTAGE_OFFSET  = 2'd1;
   localparam logic [1:0] CSR_CONVERSION_GAIN = 2'd2;
   localparam logic [1:0] CSR_FILTER_WEIGHT   = 2'd3;

   // reset values of the configuration registers
   localparam logic [30:0] COUNT_SCALE_RESET     = 31'd0;
   localparam logic [31:0] VOLTAGE_OFFSET_RESET  = 32'd0;
   localparam logic [31:0] CONVERSION_GAIN_RESET = 32'd65536;
   localparam logic [16:0] FILTER_WEIGHT_RESET   = 17'd0;

   // 1.0 in q1.16
   localparam logic [16:0] WEIGHT_ONE = 17'd65536;

   localparam logic [31:0] VALUE_MAX = 32'h7fff_ffff;
   localparam logic [31:0] VALUE_MIN = 32'h8000_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE,
      ST_OFFSET,
      ST_GAIN_LO,
      ST_GAIN_HI,
      ST_COMBINE,
      ST_FILT_V,
      ST_FILT_Q,
      ST_FINISH
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_SCALE,
      OP_OFFSET,
      OP_GAIN_LO,
      OP_GAIN_HI,
      OP_COMBINE,
      OP_FILT_V,
      OP_FILT_Q,
      OP_FINISH
   } op_type;

   typedef struct packed {
      logic   load;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic [30:0] count_scale;
      logic [31:0] voltage_offset;
      logic [31:0] conversion_gain;
      logic [16:0] filter_weight;
   } cfg_type;

endpackage

`default_nettype wire

### src/adc_channel_conditioner.sv
// adc channel conditioner: scales, offsets and gains a raw sample and low-pass filters both results
// a new sample is accepted only once the previous one has reached the result register,
// since the single 34x18 multiplier is used five times in sequence (scale, two gain halves,
// two filter products) with a register after each use
// synchronous active-high reset: registers to defaults, filter state to zero, no result pending
// depends on adcc_pkg, adcc_ctrl, adcc_dpath
`default_nettype none

module adc_channel_conditioner (
   input  wire logic               clock,
   input  wire logic               reset,
   // sample transfer
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [15:0]        req_raw_sample,
   // result transfer
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [30:0]             rsp_voltage,
   output logic signed [31:0]      rsp_scaled_value,
   output logic [30:0]             rsp_smoothed_voltage,
   output logic signed [31:0]      rsp_smoothed_value,
   // register writes
   input  wire logic               csr_write,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_wdata
);

   adcc_pkg::cmd_type cmd;
   adcc_pkg::cfg_type cfg_ff;

   // configuration registers, to be written by the user only while no sample is in flight; the block has no check
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.count_scale     <= adcc_pkg::COUNT_SCALE_RESET;
         cfg_ff.voltage_offset  <= adcc_pkg::VOLTAGE_OFFSET_RESET;
         cfg_ff.conversion_gain <= adcc_pkg::CONVERSION_GAIN_RESET;
         cfg_ff.filter_weight   <= adcc_pkg::FILTER_WEIGHT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            adcc_pkg::CSR_COUNT_SCALE:     cfg_ff.count_scale     <= csr_wdata[30:0];
            adcc_pkg::CSR_VOLTAGE_OFFSET:  cfg_ff.voltage_offset  <= csr_wdata;
            adcc_pkg::CSR_CONVERSION_GAIN: cfg_ff.conversion_gain <= csr_wdata;
            adcc_pkg::CSR_FILTER_WEIGHT:   cfg_ff.filter_weight   <= csr_wdata[16:0];
            default: begin
            end
         endcase
      end
   end

   // sequencer: one sample at a time, result held in an output register so the
   // last result can wait while the sequencer returns to idle
   adcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // datapath: shared multiplier, intermediate registers, filter state
   adcc_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .cfg                  (cfg_ff),
      .req_raw_sample       (req_raw_sample),
      .rsp_voltage          (rsp_voltage),
      .rsp_scaled_value     (rsp_scaled_value),
      .rsp_smoothed_voltage (rsp_smoothed_voltage),
      .rsp_smoothed_value   (rsp_smoothed_value)
   );

endmodule

`default_nettype wire

### src/adcc_ctrl.sv
// sequencer for the adc channel conditioner: walks one sample through the datapath
// depends on adcc_pkg
`default_nettype none

module adcc_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output adcc_pkg::cmd_type    cmd
);

   adcc_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic finish_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= adcc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output register is free when empty or being drained this cycle
   assign finish_fire = (state_ff == adcc_pkg::ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in  = state_ff;
      cmd.load  = 1'b0;
      cmd.op    = adcc_pkg::OP_NONE;
      req_stall = 1'b1;
      case (state_ff)
         adcc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = adcc_pkg::ST_SCALE;
            end
         end
         adcc_pkg::ST_SCALE: begin
            cmd.op   = adcc_pkg::OP_SCALE;
            state_in = adcc_pkg::ST_OFFSET;
         end
         adcc_pkg::ST_OFFSET: begin
            cmd.op   = adcc_pkg::OP_OFFSET;
            state_in = adcc_pkg::ST_GAIN_LO;
         end
         adcc_pkg::ST_GAIN_LO: begin
            cmd.op   = adcc_pkg::OP_GAIN_LO;
            state_in = adcc_pkg::ST_GAIN_HI;
         end
         adcc_pkg::ST_GAIN_HI: begin
            cmd.op   = adcc_pkg::OP_GAIN_HI;
            state_in = adcc_pkg::ST_COMBINE;
         end
         adcc_pkg::ST_COMBINE: begin
            cmd.op   = adcc_pkg::OP_COMBINE;
            state_in = adcc_pkg::ST_FILT_V;
         end
         adcc_pkg::ST_FILT_V: begin
            cmd.op   = adcc_pkg::OP_FILT_V;
            state_in = adcc_pkg::ST_FILT_Q;
         end
         adcc_pkg::ST_FILT_Q: begin
            cmd.op   = adcc_pkg::OP_FILT_Q;
            state_in = adcc_pkg::ST_FINISH;
         end
         adcc_pkg::ST_FINISH: begin
            if (finish_fire) begin
               cmd.op   = adcc_pkg::OP_FINISH;
               state_in = adcc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = adcc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (finish_fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### src/adcc_dpath.sv
// datapath of the adc channel conditioner: shared multiplier, filter state, result register
// depends on adcc_pkg
`default_nettype none

module adcc_dpath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire adcc_pkg::cmd_type cmd,
   input  wire adcc_pkg::cfg_type cfg,
   input  wire logic [15:0]       req_raw_sample,
   output logic [30:0]            rsp_voltage,
   output logic signed [31:0]     rsp_scaled_value,
   output logic [30:0]            rsp_smoothed_voltage,
   output logic signed [31:0]     rsp_smoothed_value
);

   logic [15:0]        raw_ff;
   logic signed [51:0] prod_ff;
   logic signed [49:0] lo_ff;
   logic [30:0]        volt_ff;
   logic [32:0]        diff_ff;
   logic [32:0]        dv_ff;
   logic [32:0]        dq_ff;
   logic [31:0]        val_ff;
   logic [31:0]        yv_ff;
   logic [31:0]        yq_ff;

   logic [30:0] out_volt_ff;
   logic [31:0] out_val_ff;
   logic [30:0] out_svolt_ff;
   logic [31:0] out_sval_ff;

   logic [16:0]        weight;
   logic signed [33:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [51:0] mul_p;
   logic               mul_en;
   logic [30:0]        volt_c;
   logic signed [51:0] val_sum;
   logic [31:0]        val_sat;
   logic [31:0]        yq_new;

   // weight above one behaves as one
   assign weight = (cfg.filter_weight > adcc_pkg::WEIGHT_ONE) ? adcc_pkg::WEIGHT_ONE
                                                             : cfg.filter_weight;

   // operand selection for the single 34x18 signed multiplier
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b0;
      case (cmd.op)
         adcc_pkg::OP_SCALE: begin
            mul_a  = {3'b000, cfg.count_scale};
            mul_b  = {2'b00, raw_ff};
            mul_en = 1'b1;
         end
         adcc_pkg::OP_GAIN_LO: begin
            mul_a  = {diff_ff[32], diff_ff};
            mul_b  = {2'b00, cfg.conversion_gain[15:0]};
            mul_en = 1'b1;
         end
         adcc_pkg::OP_GAIN_HI: begin
            mul_a  = {diff_ff[32], diff_ff};
            mul_b  = {{2{cfg.conversion_gain[31]}}, cfg.conversion_gain[31:16]};
            mul_en = 1'b1;
         end
         adcc_pkg::OP_COMBINE: begin
            mul_a  = {dv_ff[32], dv_ff};
            mul_b  = {1'b0, weight};
            mul_en = 1'b1;
         end
         adcc_pkg::OP_FILT_Q: begin
            mul_a  = {dq_ff[32], dq_ff};
            mul_b  = {1'b0, weight};
            mul_en = 1'b1;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   assign mul_p  = mul_a * mul_b;
   assign volt_c = prod_ff[46:16];

   // high partial product plus floored low partial product, then clip to 32 bits
   assign val_sum = prod_ff + {{18{lo_ff[49]}}, lo_ff[49:16]};
   always_comb begin
      if (val_sum[51:31] == {21{val_sum[51]}}) begin
         val_sat = val_sum[31:0];
      end else if (val_sum[51]) begin
         val_sat = adcc_pkg::VALUE_MIN;
      end else begin
         val_sat = adcc_pkg::VALUE_MAX;
      end
   end

   // x + floor(a * (y - x) / 2^16), always back within 32 bits
   assign yq_new = val_ff + prod_ff[47:16];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         raw_ff <= req_raw_sample;
      end
      if (mul_en) begin
         prod_ff <= mul_p;
      end
      case (cmd.op)
         adcc_pkg::OP_OFFSET: begin
            volt_ff <= volt_c;
            diff_ff <= {2'b00, volt_c} - {cfg.voltage_offset[31], cfg.voltage_offset};
            dv_ff   <= {yv_ff[31], yv_ff} - {2'b00, volt_c};
         end
         adcc_pkg::OP_GAIN_HI: begin
            lo_ff <= prod_ff[49:0];
         end
         adcc_pkg::OP_COMBINE: begin
            val_ff <= val_sat;
         end
         adcc_pkg::OP_FILT_V: begin
            dq_ff <= {yq_ff[31], yq_ff} - {val_ff[31], val_ff};
         end
         adcc_pkg::OP_FINISH: begin
            out_volt_ff  <= volt_ff;
            out_val_ff   <= val_ff;
            out_svolt_ff <= yv_ff[30:0];
            out_sval_ff  <= yq_new;
         end
         default: begin
         end
      endcase
   end

   // filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         yv_ff <= '0;
         yq_ff <= '0;
      end else begin
         if (cmd.op == adcc_pkg::OP_FILT_V) begin
            yv_ff <= {1'b0, volt_ff} + prod_ff[47:16];
         end
         if (cmd.op == adcc_pkg::OP_FINISH) begin
            yq_ff <= yq_new;
         end
      end
   end

   assign rsp_voltage          = out_volt_ff;
   assign rsp_scaled_value     = out_val_ff;
   assign rsp_smoothed_voltage = out_svolt_ff;
   assign rsp_smoothed_value   = out_sval_ff;

endmodule

`default_nettype wire

### src/adcc_checker.sv
// port-level checks for the adc channel conditioner, bound to the top level
// depends on adc_channel_conditioner ports only
`default_nettype none

module adcc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [30:0] rsp_voltage,
   input wire logic [31:0] rsp_scaled_value
);

   // an accepted sample stalls the input, so no sample is accepted right after it
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall ##1 req_stall)
   else $error("input accepted again too soon");

   // a new result only appears while the block is busy with a sample
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
   else $error("result appeared without a sample in flight");

   // a stalled result stays
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
   else $error("stalled result dropped");

   // a stalled result's voltage and scaled value do not change
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_voltage) && $stable(rsp_scaled_value)))
   else $error("stalled result changed");

endmodule

bind adc_channel_conditioner adcc_checker u_checker (.*);

`default_nettype wire

### bench/adc_channel_conditioner_tb.sv
// self-checking bench for adc_channel_conditioner: directed table then random register settings
// depends on adcc_pkg and the adc_channel_conditioner rtl; results checked in order of arrival
`default_nettype none

module adc_channel_conditioner_tb;

   // cycles with no transfer on either channel before the run is abandoned
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   // quiet cycles after the last result, well past the block's latency
   localparam int unsigned TAIL_CYCLES = 24;
   localparam int unsigned RANDOM_PHASES = 8;
   localparam int unsigned PHASE_ITEMS = 94;

   typedef struct {
      logic [30:0]        voltage;
      logic signed [31:0] scaled_value;
      logic [30:0]        smoothed_voltage;
      logic signed [31:0] smoothed_value;
   } cond_result_type;

   typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_type;

   // one line of the directed table: a register write or a sample,
   // the latter optionally with its result written out by hand
   typedef struct {
      row_kind_type    kind;
      logic [1:0]      index;
      logic [31:0]     wdata;
      logic [15:0]     raw;
      bit              typed;
      cond_result_type result;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [15:0]        req_raw_sample = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [30:0]        rsp_voltage;
   logic signed [31:0] rsp_scaled_value;
   logic [30:0]        rsp_smoothed_voltage;
   logic signed [31:0] rsp_smoothed_value;
   logic               csr_write = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   // our copy of the registers and of both filter states
   logic [30:0]        cfg_count_scale;
   logic signed [31:0] cfg_voltage_offset;
   logic signed [31:0] cfg_conversion_gain;
   logic [16:0]        cfg_filter_weight;
   logic signed [31:0] volt_lp_state;
   logic signed [31:0] value_lp_state;

   cond_result_type pending_results[$];
   cond_result_type oldest_result;
   int unsigned     error_count = 0;
   int unsigned     idle_cycles = 0;
   int unsigned     hold_cycles = 0;
   int unsigned     stall_roll;
   bit              no_idle = 1'b0;

   adc_channel_conditioner u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_raw_sample       (req_raw_sample),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_voltage          (rsp_voltage),
      .rsp_scaled_value     (rsp_scaled_value),
      .rsp_smoothed_voltage (rsp_smoothed_voltage),
      .rsp_smoothed_value   (rsp_smoothed_value),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   // 4-unit clock period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // one-pole low-pass: ((1 - a) x + a y) >> 16 with a floor shift
   function automatic logic signed [31:0] one_pole(logic signed [31:0] x,
                                                   logic signed [31:0] y,
                                                   logic [16:0] a);
      logic signed [63:0] wa;
      logic signed [63:0] wx;
      logic signed [63:0] acc;
      wa = $signed({47'd0, a});
      wx = 64'sd65536 - wa;
      acc = wx * 64'(x) + wa * 64'(y);
      return acc[47:16];
   endfunction

   // full conditioning of one sample; advances both filter states
   function automatic cond_result_type predict_conditioned(logic [15:0] raw);
      logic [46:0]        scaled;
      logic [30:0]        volt;
      logic signed [33:0] diff;
      logic signed [71:0] prod;
      logic signed [71:0] shifted;
      logic signed [31:0] value;
      logic [16:0]        weight;
      cond_result_type    res;
      scaled = {31'd0, raw} * {16'd0, cfg_count_scale};
      volt = scaled[46:16];
      diff = $signed({3'b000, volt}) - 34'(cfg_voltage_offset);
      prod = 72'(diff) * 72'(cfg_conversion_gain);
      shifted = prod >>> 16;
      // saturate the corrected value to signed 32 bits
      if (shifted > 72'($signed(adcc_pkg::VALUE_MAX))) begin
         value = adcc_pkg::VALUE_MAX;
      end else if (shifted < 72'($signed(adcc_pkg::VALUE_MIN))) begin
         value = adcc_pkg::VALUE_MIN;
      end else begin
         value = shifted[31:0];
      end
      // a weight above one behaves as exactly one: both filters hold
      weight = (cfg_filter_weight > adcc_pkg::WEIGHT_ONE) ? adcc_pkg::WEIGHT_ONE
                                                          : cfg_filter_weight;
      volt_lp_state = one_pole($signed({1'b0, volt}), volt_lp_state, weight);
      value_lp_state = one_pole(value, value_lp_state, weight);
      res.voltage = volt;
      res.scaled_value = value;
      res.smoothed_voltage = volt_lp_state[30:0];
      res.smoothed_value = value_lp_state;
      return res;
   endfunction

   function automatic stim_row_type wr(logic [1:0] index, logic [31:0] wdata);
      stim_row_type row;
      row = '{kind: ROW_WRITE, index: index, wdata: wdata, raw: '0, typed: 1'b0,
              result: '{default: '0}};
      return row;
   endfunction

   function automatic stim_row_type smp(logic [15:0] raw);
      stim_row_type row;
      row = '{kind: ROW_SAMPLE, index: '0, wdata: '0, raw: raw, typed: 1'b0,
              result: '{default: '0}};
      return row;
   endfunction

   function automatic stim_row_type chk(logic [15:0] raw, logic [30:0] v, logic [31:0] q,
                                        logic [30:0] sv, logic [31:0] sq);
      stim_row_type row;
      row = smp(raw);
      row.typed = 1'b1;
      row.result = '{voltage: v, scaled_value: q, smoothed_voltage: sv,
                     smoothed_value: sq};
      return row;
   endfunction

   // sender gap: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // register write; the caller lowers csr_write after the last of a group
   task automatic write_reg(logic [1:0] index, logic [31:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         adcc_pkg::CSR_COUNT_SCALE:     cfg_count_scale = data[30:0];
         adcc_pkg::CSR_VOLTAGE_OFFSET:  cfg_voltage_offset = data;
         adcc_pkg::CSR_CONVERSION_GAIN: cfg_conversion_gain = data;
         adcc_pkg::CSR_FILTER_WEIGHT:   cfg_filter_weight = data[16:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // present one sample and hold it until the transfer completes
   task automatic send_sample(logic [15:0] raw);
      req_valid <= 1'b1;
      req_raw_sample <= raw;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic pause_sender(int unsigned gap);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // always waits for a clock edge before it checks, so valid is never lowered and raised in one step
   task automatic wait_all_results();
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, seen);
         error_count++;
      end
   endtask

   // result stall: short bursts either way, occasional long stall, none in no_idle phases once a hold ends
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_cycles <= 0;
      end else if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
      end else if (no_idle) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 55) begin
            rsp_stall <= 1'b0;
            hold_cycles <= $urandom_range(0, 4);
         end else if (stall_roll < 95) begin
            rsp_stall <= 1'b1;
            hold_cycles <= $urandom_range(0, 3);
         end else begin
            rsp_stall <= 1'b1;
            hold_cycles <= $urandom_range(10, 40);
         end
      end
   end

   // every result transfer is matched against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %h %h %h %h", $time,
                     rsp_voltage, rsp_scaled_value, rsp_smoothed_voltage,
                     rsp_smoothed_value);
            error_count++;
         end else begin
            oldest_result = pending_results.pop_front();
            check_field("voltage", {1'b0, oldest_result.voltage}, {1'b0, rsp_voltage});
            check_field("scaled_value", oldest_result.scaled_value, rsp_scaled_value);
            check_field("smoothed_voltage", {1'b0, oldest_result.smoothed_voltage},
                        {1'b0, rsp_smoothed_voltage});
            check_field("smoothed_value", oldest_result.smoothed_value,
                        rsp_smoothed_value);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      stim_row_type    rows[$];
      cond_result_type want;
      logic [31:0]     word;
      logic [15:0]     raw;
      bit              in_write;
      in_write = 1'b0;
      cfg_count_scale = adcc_pkg::COUNT_SCALE_RESET;
      cfg_voltage_offset = adcc_pkg::VOLTAGE_OFFSET_RESET;
      cfg_conversion_gain = adcc_pkg::CONVERSION_GAIN_RESET;
      cfg_filter_weight = adcc_pkg::FILTER_WEIGHT_RESET;
      volt_lp_state = '0;
      value_lp_state = '0;

      // registers at reset: zero scale gives zero everywhere
      rows.push_back(chk(16'h0000, 31'd0, 32'd0, 31'd0, 32'd0));
      rows.push_back(chk(16'hffff, 31'd0, 32'd0, 31'd0, 32'd0));
      // unity scale and gain, filters pass straight through
      rows.push_back(wr(adcc_pkg::CSR_COUNT_SCALE, 32'd65536));
      rows.push_back(wr(adcc_pkg::CSR_VOLTAGE_OFFSET, 32'd0));
      rows.push_back(wr(adcc_pkg::CSR_CONVERSION_GAIN, 32'd65536));
      rows.push_back(wr(adcc_pkg::CSR_FILTER_WEIGHT, 32'd0));
      rows.push_back(chk(16'hffff, 31'd65535, 32'd65535, 31'd65535, 32'd65535));
      rows.push_back(chk(16'h0000, 31'd0, 32'd0, 31'd0, 32'd0));
      rows.push_back(smp(16'h5a5a));
      rows.push_back(smp(16'ha5a5));
      // most negative offset with largest gain: positive saturation
      rows.push_back(wr(adcc_pkg::CSR_VOLTAGE_OFFSET, adcc_pkg::VALUE_MIN));
      rows.push_back(wr(adcc_pkg::CSR_CONVERSION_GAIN, adcc_pkg::VALUE_MAX));
      rows.push_back(chk(16'hffff, 31'd65535, adcc_pkg::VALUE_MAX,
                         31'd65535, adcc_pkg::VALUE_MAX));
      // weight field all ones, above one: filters hold their last outputs
      rows.push_back(wr(adcc_pkg::CSR_FILTER_WEIGHT, 32'hffff_ffff));
      rows.push_back(chk(16'h0000, 31'd0, adcc_pkg::VALUE_MAX,
                         31'd65535, adcc_pkg::VALUE_MAX));
      rows.push_back(smp(16'h1234));
      // largest offset: negative saturation, weight exactly one still holds
      rows.push_back(wr(adcc_pkg::CSR_VOLTAGE_OFFSET, adcc_pkg::VALUE_MAX));
      rows.push_back(wr(adcc_pkg::CSR_FILTER_WEIGHT, {15'd0, adcc_pkg::WEIGHT_ONE}));
      rows.push_back(chk(16'h0000, 31'd0, adcc_pkg::VALUE_MIN,
                         31'd65535, adcc_pkg::VALUE_MAX));
      // most negative gain, full scale, half weight
      rows.push_back(wr(adcc_pkg::CSR_CONVERSION_GAIN, adcc_pkg::VALUE_MIN));
      rows.push_back(wr(adcc_pkg::CSR_VOLTAGE_OFFSET, adcc_pkg::VALUE_MIN));
      rows.push_back(wr(adcc_pkg::CSR_FILTER_WEIGHT, 32'd32768));
      rows.push_back(wr(adcc_pkg::CSR_COUNT_SCALE, 32'hffff_ffff));
      rows.push_back(smp(16'hffff));
      rows.push_back(smp(16'h0000));
      rows.push_back(smp(16'h8001));
      // tiny scale with junk in bit 31, gain of minus one: floor of negatives
      rows.push_back(wr(adcc_pkg::CSR_COUNT_SCALE, 32'h8000_0001));
      rows.push_back(wr(adcc_pkg::CSR_VOLTAGE_OFFSET, 32'd1));
      rows.push_back(wr(adcc_pkg::CSR_CONVERSION_GAIN, 32'hffff_0000));
      rows.push_back(wr(adcc_pkg::CSR_FILTER_WEIGHT, 32'hfffe_ffff));
      rows.push_back(smp(16'hffff));
      rows.push_back(smp(16'h0001));
      rows.push_back(smp(16'h7fff));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (rows[i]) begin
         if (rows[i].kind == ROW_WRITE) begin
            // registers only change once the block has drained
            if (!in_write) begin
               req_valid <= 1'b0;
               wait_all_results();
            end
            write_reg(rows[i].index, rows[i].wdata);
            in_write = 1'b1;
         end else begin
            if (in_write) csr_write <= 1'b0;
            in_write = 1'b0;
            send_sample(rows[i].raw);
            // the predictor runs on every sample row to keep its filter states in step
            want = predict_conditioned(rows[i].raw);
            pending_results.push_back(rows[i].typed ? rows[i].result : want);
            pause_sender(pick_gap());
         end
      end

      // random phases, each with a fresh register setting
      for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
         req_valid <= 1'b0;
         wait_all_results();
         no_idle = (ph % 3 == 2);

         word = $urandom;
         case ($urandom_range(0, 4))
            0: word[30:0] = '1;
            1: word[30:0] = '0;
            2: word[30:0] = 31'd65536;
            3: word[30:0] = 31'($urandom_range(0, 1 << 20));
            default: ;
         endcase
         write_reg(adcc_pkg::CSR_COUNT_SCALE, word);

         case ($urandom_range(0, 4))
            0: word = adcc_pkg::VALUE_MIN;
            1: word = adcc_pkg::VALUE_MAX;
            2: word = '0;
            3: word = $urandom_range(0, 1 << 21) - (1 << 20);
            default: word = $urandom;
         endcase
         write_reg(adcc_pkg::CSR_VOLTAGE_OFFSET, word);

         case ($urandom_range(0, 4))
            0: word = adcc_pkg::VALUE_MIN;
            1: word = adcc_pkg::VALUE_MAX;
            2: word = adcc_pkg::CONVERSION_GAIN_RESET;
            3: word = $urandom_range(0, 1 << 19) - (1 << 18);
            default: word = $urandom;
         endcase
         write_reg(adcc_pkg::CSR_CONVERSION_GAIN, word);

         word = $urandom;
         case ($urandom_range(0, 4))
            0: word[16:0] = '0;
            1: word[16:0] = adcc_pkg::WEIGHT_ONE;
            2: word[16:0] = 17'($urandom_range(65537, 131071));
            3: word[16:0] = 17'd65535;
            default: word[16:0] = 17'($urandom_range(0, 65535));
         endcase
         write_reg(adcc_pkg::CSR_FILTER_WEIGHT, word);
         csr_write <= 1'b0;

         for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
            // in even phases the sender holds off mid-phase until the pipeline is empty
            if (n == PHASE_ITEMS / 2 && ph % 2 == 0) begin
               req_valid <= 1'b0;
               wait_all_results();
            end
            case ($urandom_range(0, 19))
               0: raw = 16'h0000;
               1: raw = 16'hffff;
               default: raw = 16'($urandom_range(0, 65535));
            endcase
            send_sample(raw);
            pending_results.push_back(predict_conditioned(raw));
            pause_sender(pick_gap());
         end
      end

      // drain, then a quiet tail to catch any stray transfer
      req_valid <= 1'b0;
      wait_all_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
